/* hw/rtl/tbh_pkg.sv */
// Shared types, codes and the byte classifier for the text bigram histogram unit.
package tbh_pkg;

  localparam int NUM_KEYS     = 36;
  localparam int KEY_W        = 6;
  localparam int BIGRAM_DEPTH = NUM_KEYS * NUM_KEYS;
  localparam int BG_ADDR_W    = 11;
  localparam int IDX_W        = 11;
  localparam int LEN_FIELD_W  = 8;
  localparam int NUM_SYMBOLS  = 10;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [KEY_W-1:0] NONE_KEY = 6'd63;
  localparam logic [KEY_W-1:0] SYM_BASE = 6'd26;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  // Symbol pairs, unshifted and shifted, in key order.
  localparam logic [7:0] SYM_LO [NUM_SYMBOLS] =
    '{8'h60, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h3B, 8'h27, 8'h2C, 8'h2E, 8'h2F};
  localparam logic [7:0] SYM_HI [NUM_SYMBOLS] =
    '{8'h7E, 8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h3A, 8'h22, 8'h3C, 8'h3E, 8'h3F};

  localparam logic [1:0] CMD_TEXT = 2'd0;
  localparam logic [1:0] CMD_END  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic CFG_INCLUDE_SYMBOLS = 1'b0;
  localparam logic CFG_KEYSTROKE_MODE  = 1'b1;

  typedef enum logic [1:0] {
    SEL_BIGRAM = 2'd0,
    SEL_KEY    = 2'd1,
    SEL_START  = 2'd2,
    SEL_LENGTH = 2'd3
  } table_sel_t;

  typedef struct packed {
    logic             is_key;
    logic [KEY_W-1:0] key;
  } class_t;

  // One unit of work for the counter back end.
  typedef struct packed {
    logic                   is_read;
    table_sel_t             sel;
    logic                   err;
    logic                   key_en;
    logic                   start_en;
    logic [KEY_W-1:0]       key_addr;
    logic                   bg_en;
    logic [BG_ADDR_W-1:0]   bg_addr;
    logic                   len_en;
    logic [LEN_FIELD_W-1:0] len_addr;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic class_t classify(input logic [7:0] b, input logic with_symbols);
    class_t c;
    c.is_key = 1'b0;
    c.key    = NONE_KEY;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      c.is_key = 1'b1;
      c.key    = KEY_W'(b - CHAR_UPPER_A);
    end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
      c.is_key = 1'b1;
      c.key    = KEY_W'(b - CHAR_LOWER_A);
    end else if (with_symbols) begin
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        if (!c.is_key && (b == SYM_LO[i] || b == SYM_HI[i])) begin
          c.is_key = 1'b1;
          c.key    = SYM_BASE + KEY_W'(i);
        end
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/tbh_in_if.sv */
// Input channel: command, text byte and read selection with valid/ready.
interface tbh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  char_byte;
  logic [1:0]  table_select;
  logic [10:0] read_index;

  modport source (output valid, output cmd, output char_byte, output table_select,
                  output read_index, input ready);
  modport sink (input valid, input cmd, input char_byte, input table_select,
                input read_index, output ready);
endinterface

/* hw/rtl/tbh_out_if.sv */
// Output channel: counter value and index error with valid/ready.
interface tbh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] count_value;
  logic        index_error;

  modport source (output valid, output count_value, output index_error, input ready);
  modport sink (input valid, input count_value, input index_error, output ready);
endinterface

/* hw/rtl/tbh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/tbh_front.sv */
// Front end: accepts items, classifies bytes, tracks word state and issues counter work.
module tbh_front #(
  parameter int MAX_WORD_LEN = 32
) (
  input  logic           clk,
  input  logic           rst,
  tbh_in_if.sink         in_ch,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic           cfg_wdata,
  input  logic           clearing,
  input  logic           q_full,
  output logic           push,
  output tbh_pkg::op_t   push_op
);

  localparam int LW = $clog2(MAX_WORD_LEN);

  logic                       include_symbols;
  logic                       keystroke_mode;
  logic [tbh_pkg::KEY_W-1:0]  previous_key;
  logic [tbh_pkg::KEY_W-1:0]  previous_key_next;
  logic                       chain_broken;
  logic                       chain_broken_next;
  logic [LW-1:0]              word_len;
  logic [LW-1:0]              word_len_next;
  logic                       accept;
  logic                       op_needed;
  tbh_pkg::class_t            cls;
  tbh_pkg::op_t               op;

  assign in_ch.ready = !q_full && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && op_needed;
  assign push_op     = op;

  always_comb begin
    cls               = tbh_pkg::classify(in_ch.char_byte, include_symbols);
    previous_key_next = previous_key;
    chain_broken_next = chain_broken;
    word_len_next     = word_len;
    op_needed         = 1'b0;
    op                = '0;
    case (in_ch.cmd)
      tbh_pkg::CMD_TEXT: begin
        if (cls.is_key) begin
          op_needed   = 1'b1;
          op.key_en   = 1'b1;
          op.key_addr = cls.key;
          op.start_en = (word_len == '0);
          op.bg_en    = (previous_key != tbh_pkg::NONE_KEY) && !chain_broken;
          op.bg_addr  = tbh_pkg::BG_ADDR_W'(
                          tbh_pkg::BG_ADDR_W'(previous_key)
                          * tbh_pkg::BG_ADDR_W'(tbh_pkg::NUM_KEYS)
                          + tbh_pkg::BG_ADDR_W'(cls.key));
          if (word_len < LW'(MAX_WORD_LEN - 1)) begin
            word_len_next = word_len + LW'(1);
          end
          previous_key_next = cls.key;
          chain_broken_next = 1'b0;
        end else begin
          if (word_len != '0) begin
            op_needed   = 1'b1;
            op.len_en   = 1'b1;
            op.len_addr = tbh_pkg::LEN_FIELD_W'(word_len);
            if (!keystroke_mode) begin
              chain_broken_next = 1'b1;
            end
          end
          word_len_next = '0;
        end
      end
      tbh_pkg::CMD_END: begin
        if (word_len != '0) begin
          op_needed   = 1'b1;
          op.len_en   = 1'b1;
          op.len_addr = tbh_pkg::LEN_FIELD_W'(word_len);
        end
        word_len_next     = '0;
        previous_key_next = tbh_pkg::NONE_KEY;
        chain_broken_next = 1'b0;
      end
      tbh_pkg::CMD_READ: begin
        op_needed  = 1'b1;
        op.is_read = 1'b1;
        op.sel     = tbh_pkg::table_sel_t'(in_ch.table_select);
        unique case (op.sel)
          tbh_pkg::SEL_BIGRAM: begin
            op.err     = in_ch.read_index >= tbh_pkg::IDX_W'(tbh_pkg::BIGRAM_DEPTH);
            op.bg_addr = in_ch.read_index;
          end
          tbh_pkg::SEL_KEY, tbh_pkg::SEL_START: begin
            op.err      = in_ch.read_index >= tbh_pkg::IDX_W'(tbh_pkg::NUM_KEYS);
            op.key_addr = in_ch.read_index[tbh_pkg::KEY_W-1:0];
          end
          tbh_pkg::SEL_LENGTH: begin
            op.err      = in_ch.read_index >= tbh_pkg::IDX_W'(MAX_WORD_LEN);
            op.len_addr = in_ch.read_index[tbh_pkg::LEN_FIELD_W-1:0];
          end
          default: op.err = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      include_symbols <= 1'b0;
      keystroke_mode  <= 1'b0;
      previous_key    <= tbh_pkg::NONE_KEY;
      chain_broken    <= 1'b0;
      word_len        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tbh_pkg::CFG_INCLUDE_SYMBOLS: include_symbols <= cfg_wdata;
          tbh_pkg::CFG_KEYSTROKE_MODE:  keystroke_mode  <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        previous_key <= previous_key_next;
        chain_broken <= chain_broken_next;
        word_len     <= word_len_next;
      end
    end
  end

endmodule

/* hw/rtl/tbh_queue.sv */
// Short queue of counter work between the front and back ends.
module tbh_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tbh_pkg::op_t        push_op,
  input  logic                pop,
  output tbh_pkg::op_t        head_op,
  output tbh_pkg::q_status_t  status
);

  tbh_pkg::op_t                  entries [tbh_pkg::QUEUE_DEPTH];
  logic [tbh_pkg::QPTR_W-1:0]    wr_ptr;
  logic [tbh_pkg::QPTR_W-1:0]    rd_ptr;
  logic [tbh_pkg::QCNT_W-1:0]    count;

  assign head_op      = entries[rd_ptr];
  assign status.full  = (count == tbh_pkg::QCNT_W'(tbh_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_op;
        wr_ptr          <= wr_ptr + tbh_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tbh_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + tbh_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - tbh_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/tbh_back.sv */
// Back end: counter RAMs with read-modify-write, forwarding, clearing pass and read results.
module tbh_back #(
  parameter int MAX_WORD_LEN = 32,
  parameter int COUNT_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  tbh_pkg::op_t        head_op,
  input  logic                q_empty,
  output logic                pop,
  output logic                clearing,
  tbh_out_if.source           out_ch
);

  localparam int LW = $clog2(MAX_WORD_LEN);
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic [tbh_pkg::BG_ADDR_W-1:0] clr_idx;
  logic                          back_adv;
  logic                          w_valid;
  tbh_pkg::op_t                  w_op;

  logic [COUNT_BITS-1:0] rd_bg, rd_key, rd_st, rd_len;
  logic [COUNT_BITS-1:0] val_bg, val_key, val_st, val_len;
  logic [COUNT_BITS-1:0] wd_bg, wd_key, wd_st, wd_len;
  logic                  we_bg, we_key, we_st, we_len;
  logic [tbh_pkg::BG_ADDR_W-1:0] wa_bg;
  logic [tbh_pkg::KEY_W-1:0]     wa_key;
  logic [LW-1:0]                 wa_len;
  logic [LW-1:0]                 w_len_addr;
  logic [LW-1:0]                 head_len_addr;

  // Most recent write into each RAM, used to forward over the read latency.
  logic                          lw_bg_v, lw_key_v, lw_st_v, lw_len_v;
  logic [tbh_pkg::BG_ADDR_W-1:0] lw_bg_a;
  logic [tbh_pkg::KEY_W-1:0]     lw_key_a, lw_st_a;
  logic [LW-1:0]                 lw_len_a;
  logic [COUNT_BITS-1:0]         lw_bg_d, lw_key_d, lw_st_d, lw_len_d;

  logic [COUNT_BITS-1:0] sel_val;
  logic [31:0]           sat_val;
  logic                  out_valid;
  logic [31:0]           out_count;
  logic                  out_err;

  assign back_adv = !(w_valid && w_op.is_read && out_valid && !out_ch.ready);
  assign pop      = back_adv && !clearing && !q_empty;

  assign w_len_addr    = w_op.len_addr[LW-1:0];
  assign head_len_addr = head_op.len_addr[LW-1:0];

  assign val_bg  = (lw_bg_v && lw_bg_a == w_op.bg_addr) ? lw_bg_d : rd_bg;
  assign val_key = (lw_key_v && lw_key_a == w_op.key_addr) ? lw_key_d : rd_key;
  assign val_st  = (lw_st_v && lw_st_a == w_op.key_addr) ? lw_st_d : rd_st;
  assign val_len = (lw_len_v && lw_len_a == w_len_addr) ? lw_len_d : rd_len;

  always_comb begin
    if (clearing) begin
      we_bg  = 1'b1;
      we_key = clr_idx < tbh_pkg::BG_ADDR_W'(tbh_pkg::NUM_KEYS);
      we_st  = we_key;
      we_len = clr_idx < tbh_pkg::BG_ADDR_W'(MAX_WORD_LEN);
      wa_bg  = clr_idx;
      wa_key = clr_idx[tbh_pkg::KEY_W-1:0];
      wa_len = clr_idx[LW-1:0];
      wd_bg  = '0;
      wd_key = '0;
      wd_st  = '0;
      wd_len = '0;
    end else begin
      we_bg  = w_valid && !w_op.is_read && w_op.bg_en;
      we_key = w_valid && !w_op.is_read && w_op.key_en;
      we_st  = w_valid && !w_op.is_read && w_op.start_en;
      we_len = w_valid && !w_op.is_read && w_op.len_en;
      wa_bg  = w_op.bg_addr;
      wa_key = w_op.key_addr;
      wa_len = w_len_addr;
      wd_bg  = (val_bg == '1) ? val_bg : val_bg + COUNT_ONE;
      wd_key = (val_key == '1) ? val_key : val_key + COUNT_ONE;
      wd_st  = (val_st == '1) ? val_st : val_st + COUNT_ONE;
      wd_len = (val_len == '1) ? val_len : val_len + COUNT_ONE;
    end
  end

  tbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(tbh_pkg::BIGRAM_DEPTH)) u_bigram_ram (
    .clk(clk), .we(we_bg), .waddr(wa_bg), .wdata(wd_bg),
    .re(back_adv), .raddr(head_op.bg_addr), .rdata(rd_bg)
  );

  tbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(tbh_pkg::NUM_KEYS)) u_key_ram (
    .clk(clk), .we(we_key), .waddr(wa_key), .wdata(wd_key),
    .re(back_adv), .raddr(head_op.key_addr), .rdata(rd_key)
  );

  tbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(tbh_pkg::NUM_KEYS)) u_start_ram (
    .clk(clk), .we(we_st), .waddr(wa_key), .wdata(wd_st),
    .re(back_adv), .raddr(head_op.key_addr), .rdata(rd_st)
  );

  tbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_WORD_LEN)) u_length_ram (
    .clk(clk), .we(we_len), .waddr(wa_len), .wdata(wd_len),
    .re(back_adv), .raddr(head_len_addr), .rdata(rd_len)
  );

  always_comb begin
    case (w_op.sel)
      tbh_pkg::SEL_BIGRAM: sel_val = val_bg;
      tbh_pkg::SEL_KEY:    sel_val = val_key;
      tbh_pkg::SEL_START:  sel_val = val_st;
      default:             sel_val = val_len;
    endcase
  end

  generate
    if (COUNT_BITS > 32) begin : g_sat_wide
      assign sat_val = (|sel_val[COUNT_BITS-1:32]) ? '1 : sel_val[31:0];
    end else begin : g_sat_narrow
      assign sat_val = 32'(sel_val);
    end
  endgenerate

  assign out_ch.valid       = out_valid;
  assign out_ch.count_value = out_count;
  assign out_ch.index_error = out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      w_valid   <= 1'b0;
      out_valid <= 1'b0;
      lw_bg_v   <= 1'b0;
      lw_key_v  <= 1'b0;
      lw_st_v   <= 1'b0;
      lw_len_v  <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + tbh_pkg::BG_ADDR_W'(1);
        if (clr_idx == tbh_pkg::BG_ADDR_W'(tbh_pkg::BIGRAM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (back_adv) begin
        w_valid <= pop;
        w_op    <= head_op;
      end
      if (back_adv && w_valid && w_op.is_read) begin
        out_valid <= 1'b1;
        out_count <= w_op.err ? '0 : sat_val;
        out_err   <= w_op.err;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (we_bg) begin
        lw_bg_v <= 1'b1;
        lw_bg_a <= wa_bg;
        lw_bg_d <= wd_bg;
      end
      if (we_key) begin
        lw_key_v <= 1'b1;
        lw_key_a <= wa_key;
        lw_key_d <= wd_key;
      end
      if (we_st) begin
        lw_st_v <= 1'b1;
        lw_st_a <= wa_key;
        lw_st_d <= wd_st;
      end
      if (we_len) begin
        lw_len_v <= 1'b1;
        lw_len_a <= wa_len;
        lw_len_d <= wd_len;
      end
    end
  end

endmodule

/* hw/rtl/text_bigram_histogram_unit.sv */
// Top level of the text bigram histogram unit: front end, work queue and counter back end.
//
//   Channel  Role    Handshake      Contents
//   in_ch    sink    valid/ready    cmd, char_byte, table_select, read_index
//   out_ch   source  valid/ready    count_value, index_error (one per read command)
//   cfg      write   cfg_we         cfg_index, cfg_wdata (include_symbols, keystroke_mode)
//
// One input transfer is taken per cycle, unless the queue is full or clearing is running.
// A read result passes from the queue, where the counter RAM is read as it is popped,
// through the update stage to the output register.
// After reset a clearing pass zeroes every counter RAM, one entry per cycle, across the
// 1296 entries of the bigram RAM; in_ch.ready stays low during the pass.
// A stalled output holds the update stage once a read result waits there; the four-entry
// queue then fills and in_ch.ready drops while the queue is full.
module text_bigram_histogram_unit #(
  parameter int MAX_WORD_LEN = 32,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  tbh_in_if.sink      in_ch,
  tbh_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  // Work items flow front -> queue -> back. The front owns the word and chain state, so
  // it can classify a new byte in every ready cycle without waiting on the counter RAMs.
  logic                 push;
  logic                 pop;
  logic                 clearing;
  tbh_pkg::op_t         push_op;
  tbh_pkg::op_t         head_op;
  tbh_pkg::q_status_t   q_status;

  tbh_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .q_full    (q_status.full),
    .push      (push),
    .push_op   (push_op)
  );

  // The queue decouples the two halves so that an output stall does not
  // immediately reach the input side.
  tbh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .status  (q_status)
  );

  // The back end does the read-modify-write of every counter touched by an item in
  // parallel, forwarding the last written value to cover the RAM read latency.
  tbh_back #(.MAX_WORD_LEN(MAX_WORD_LEN), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head_op  (head_op),
    .q_empty  (q_status.empty),
    .pop      (pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // No input transfer may land while the counters are still being cleared.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> !clearing)
    else $error("input transfer during clearing pass");

  // The front must never push work into a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("push into full work queue");

  // The back end must never take work from an empty queue.
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty work queue");

  // Once the clearing pass has finished it does not restart without a reset.
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("clearing pass restarted");
`endif

endmodule

/* dv/text_bigram_histogram_unit_test.sv */
// Self-checking testbench for the text bigram histogram unit.
`timescale 1ns / 1ps

module text_bigram_histogram_unit_test;

  localparam int CLK_PERIOD = 12;
  localparam int WORD_MAX   = 32;
  localparam int PHASES     = 6;
  localparam int PER_PHASE  = 62;
  // Cycles allowed after the last expected read for trailing text updates to retire.
  localparam int SETTLE     = 10;
  localparam int DRAIN_MAX  = 5000;
  localparam int PRINT_MAX  = 20;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [31:0] COUNT_TOP  = 32'hFFFF_FFFF;

  // One input transfer as the testbench sees it.
  typedef struct packed {
    logic [1:0]          cmd;
    logic [7:0]          ch;
    tbh_pkg::table_sel_t sel;
    logic [10:0]         idx;
  } text_item_t;

  // What one read command is expected to return.
  typedef struct packed {
    logic [31:0] count;
    logic        err;
  } tally_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic cfg_wdata;

  tbh_in_if  in_ch ();
  tbh_out_if out_ch ();

  text_bigram_histogram_unit #(
    .MAX_WORD_LEN(WORD_MAX),
    .COUNT_BITS  (32)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Stimulus waiting to be driven, and read results still owed by the block.
  text_item_t pend_q[$];
  tally_t     read_q[$];
  text_item_t cur_item;

  // Shadow copy of the block's configuration and counter state.
  bit          sym_on;
  bit          link_words;
  int          last_key;      // -1 stands for the start-of-text marker
  bit          chain_cut;
  int          word_len;
  logic [31:0] pair_cnt [tbh_pkg::BIGRAM_DEPTH];
  logic [31:0] freq_cnt [tbh_pkg::NUM_KEYS];
  logic [31:0] head_cnt [tbh_pkg::NUM_KEYS];
  logic [31:0] len_cnt  [WORD_MAX];

  int errors;
  int in_count;
  int reads_checked;
  int settings_used;
  int snd_idle_pct;
  int rcv_idle_pct;

  // Keys the generator emitted last, so that bigram reads can target live entries.
  int gen_prev;
  int gen_cur;

  bit sym_plan [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  bit link_plan[PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == COUNT_TOP) ? v : v + 32'd1;
  endfunction

  // Folds a byte into a key, or -1 when the byte separates words. Symbol pairs
  // only count as keys while symbols are enabled.
  function automatic int key_of(input logic [7:0] b);
    int k;
    k = -1;
    if (b >= tbh_pkg::CHAR_UPPER_A && b <= tbh_pkg::CHAR_UPPER_Z) begin
      k = int'(b - tbh_pkg::CHAR_UPPER_A);
    end else if (b >= tbh_pkg::CHAR_LOWER_A && b <= tbh_pkg::CHAR_LOWER_Z) begin
      k = int'(b - tbh_pkg::CHAR_LOWER_A);
    end else if (sym_on) begin
      for (int i = tbh_pkg::NUM_SYMBOLS - 1; i >= 0; i--) begin
        if (b == tbh_pkg::SYM_LO[i] || b == tbh_pkg::SYM_HI[i]) begin
          k = int'(tbh_pkg::SYM_BASE) + i;
        end
      end
    end
    return k;
  endfunction

  // A pending word goes into the length histogram, with long words clamped into
  // the top bin. An empty word records nothing.
  task automatic close_word();
    int bin;
    bin = word_len;
    if (bin != 0) begin
      if (bin > WORD_MAX - 1) bin = WORD_MAX - 1;
      len_cnt[bin] = sat_inc(len_cnt[bin]);
    end
  endtask

  task automatic tally_step(input text_item_t it);
    int     k;
    int     pair;
    tally_t r;
    case (it.cmd)
      tbh_pkg::CMD_TEXT: begin
        k = key_of(it.ch);
        if (k < 0) begin
          // Only a separator that actually ends a word can break the chain.
          if (word_len != 0) begin
            close_word();
            if (!link_words) chain_cut = 1'b1;
          end
          word_len = 0;
        end else begin
          freq_cnt[k] = sat_inc(freq_cnt[k]);
          if (word_len == 0) head_cnt[k] = sat_inc(head_cnt[k]);
          if (last_key >= 0 && !chain_cut) begin
            pair           = last_key * tbh_pkg::NUM_KEYS + k;
            pair_cnt[pair] = sat_inc(pair_cnt[pair]);
          end
          if (word_len < WORD_MAX - 1) word_len++;
          last_key  = k;
          chain_cut = 1'b0;
        end
      end
      tbh_pkg::CMD_END: begin
        close_word();
        word_len  = 0;
        last_key  = -1;
        chain_cut = 1'b0;
      end
      tbh_pkg::CMD_READ: begin
        r = '0;
        case (it.sel)
          tbh_pkg::SEL_BIGRAM: begin
            if (it.idx < tbh_pkg::BIGRAM_DEPTH) r.count = pair_cnt[it.idx];
            else r.err = 1'b1;
          end
          tbh_pkg::SEL_KEY: begin
            if (it.idx < tbh_pkg::NUM_KEYS) r.count = freq_cnt[it.idx];
            else r.err = 1'b1;
          end
          tbh_pkg::SEL_START: begin
            if (it.idx < tbh_pkg::NUM_KEYS) r.count = head_cnt[it.idx];
            else r.err = 1'b1;
          end
          default: begin
            if (it.idx < WORD_MAX) r.count = len_cnt[it.idx];
            else r.err = 1'b1;
          end
        endcase
        read_q.push_back(r);
      end
      default: ;  // The unused command leaves everything as it was.
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item per transfer, with random gaps on the sending side.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        tally_step(cur_item);
        in_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          cur_item            = pend_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.cmd          <= cur_item.cmd;
          in_ch.char_byte    <= cur_item.ch;
          in_ch.table_select <= cur_item.sel;
          in_ch.read_index   <= cur_item.idx;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every read result is checked against the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    tally_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (read_q.size() == 0) begin
          errors++;
          if (errors <= PRINT_MAX) begin
            $display("%0t: result with no pending read, expected none, got value %0d error %0b",
                     $time, out_ch.count_value, out_ch.index_error);
          end
        end else begin
          want = read_q.pop_front();
          reads_checked++;
          if (out_ch.count_value !== want.count) begin
            errors++;
            if (errors <= PRINT_MAX) begin
              $display("%0t: count_value mismatch, expected %0d, got %0d",
                       $time, want.count, out_ch.count_value);
            end
          end
          if (out_ch.index_error !== want.err) begin
            errors++;
            if (errors <= PRINT_MAX) begin
              $display("%0t: index_error mismatch, expected %0b, got %0b",
                       $time, want.err, out_ch.index_error);
            end
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] ch,
                            input logic [1:0] sel, input logic [10:0] idx);
    text_item_t it;
    it.cmd = cmd;
    it.ch  = ch;
    it.sel = tbh_pkg::table_sel_t'(sel);
    it.idx = idx;
    pend_q.push_back(it);
  endtask

  // Text byte with the read fields filled with junk, which the block must ignore.
  task automatic queue_text(input logic [7:0] ch);
    queue_item(tbh_pkg::CMD_TEXT, ch, 2'($urandom), 11'($urandom));
  endtask

  task automatic queue_read(input tbh_pkg::table_sel_t sel, input logic [10:0] idx);
    queue_item(tbh_pkg::CMD_READ, 8'($urandom), sel, idx);
  endtask

  // A printable form of a key, picking either case or either symbol of the pair.
  function automatic logic [7:0] glyph(input int k);
    if (k < 26) begin
      return ($urandom_range(0, 1) ? tbh_pkg::CHAR_UPPER_A : tbh_pkg::CHAR_LOWER_A) + 8'(k);
    end
    return $urandom_range(0, 1) ? tbh_pkg::SYM_HI[k - 26] : tbh_pkg::SYM_LO[k - 26];
  endfunction

  // A byte that is never a key in any setting.
  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 4))
      0:       return 8'h20;
      1:       return 8'h0A;
      2:       return 8'hFF;
      3:       return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'h80 + 8'($urandom_range(0, 126));
    endcase
  endfunction

  // Writes both registers on back-to-back edges; the predictor follows at once,
  // since nothing is in flight when this runs.
  task automatic set_mode(input bit sym, input bit link);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tbh_pkg::CFG_INCLUDE_SYMBOLS;
    cfg_wdata <= sym;
    @(posedge clk);
    cfg_index <= tbh_pkg::CFG_KEYSTROKE_MODE;
    cfg_wdata <= link;
    @(posedge clk);
    cfg_we     <= 1'b0;
    sym_on      = sym;
    link_words  = link;
    settings_used++;
  endtask

  // Edge cases first: letter extremes, a symbol and FF, 00 and 80 as separators, a broken
  // chain, an empty word at end of text, the unused command and reads at table edges.
  task automatic load_directed();
    queue_text(tbh_pkg::CHAR_UPPER_A);
    queue_text(tbh_pkg::CHAR_LOWER_Z);
    queue_text(tbh_pkg::CHAR_UPPER_Z);
    queue_text(tbh_pkg::CHAR_LOWER_A);
    queue_text(tbh_pkg::SYM_LO[0]);  // a symbol is a separator while symbols are off
    queue_text(8'hFF);               // separator with no pending word
    queue_text(8'h4D);               // the chain is broken here, so no bigram
    queue_text(8'h00);
    queue_text(8'h80);
    queue_text(8'h71);
    queue_item(tbh_pkg::CMD_END, 8'hFF, tbh_pkg::SEL_LENGTH, 11'h7FF);
    queue_item(tbh_pkg::CMD_END, 8'h00, tbh_pkg::SEL_BIGRAM, 11'h000);  // nothing pending
    queue_item(CMD_UNUSED, 8'($urandom), 2'($urandom), 11'($urandom));
    queue_read(tbh_pkg::SEL_BIGRAM, 11'(25));
    queue_read(tbh_pkg::SEL_BIGRAM, 11'(tbh_pkg::BIGRAM_DEPTH - 1));
    queue_read(tbh_pkg::SEL_BIGRAM, 11'(tbh_pkg::BIGRAM_DEPTH));
    queue_read(tbh_pkg::SEL_BIGRAM, 11'h7FF);
    queue_read(tbh_pkg::SEL_KEY, 11'(0));
    queue_read(tbh_pkg::SEL_KEY, 11'(tbh_pkg::NUM_KEYS - 1));
    queue_read(tbh_pkg::SEL_KEY, 11'(tbh_pkg::NUM_KEYS));
    queue_read(tbh_pkg::SEL_START, 11'(25));
    queue_read(tbh_pkg::SEL_START, 11'(tbh_pkg::NUM_KEYS));
    queue_read(tbh_pkg::SEL_LENGTH, 11'(0));
    queue_read(tbh_pkg::SEL_LENGTH, 11'(4));
    queue_read(tbh_pkg::SEL_LENGTH, 11'(WORD_MAX - 1));
    queue_read(tbh_pkg::SEL_LENGTH, 11'(WORD_MAX));
  endtask

  // Mostly real words of random keys ended by separators or end of text, mixed
  // with reads aimed at live entries, raw noise bytes and the unused command.
  task automatic fill_random(input int n);
    int                  made;
    int                  roll;
    int                  len;
    int                  k;
    tbh_pkg::table_sel_t sel;
    logic [10:0]         idx;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          k = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 25) : $urandom_range(0, 35);
          gen_prev = gen_cur;
          gen_cur  = k;
          queue_text(glyph(k));
        end
        if ($urandom_range(0, 9) == 0) begin
          queue_item(tbh_pkg::CMD_END, 8'($urandom), 2'($urandom), 11'($urandom));
        end else begin
          queue_text(sep_byte());
        end
        made += len + 1;
      end else if (roll < 80) begin
        sel = tbh_pkg::table_sel_t'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        case (sel)
          tbh_pkg::SEL_BIGRAM: begin
            if (roll < 60)      idx = 11'(gen_prev * tbh_pkg::NUM_KEYS + gen_cur);
            else if (roll < 85) idx = 11'($urandom_range(0, tbh_pkg::BIGRAM_DEPTH - 1));
            else                idx = 11'($urandom_range(0, 2047));
          end
          tbh_pkg::SEL_LENGTH: idx = (roll < 80) ? 11'($urandom_range(0, WORD_MAX - 1))
                                                 : 11'($urandom_range(0, 2047));
          default:             idx = (roll < 80) ? 11'($urandom_range(0, tbh_pkg::NUM_KEYS - 1))
                                                 : 11'($urandom_range(0, 2047));
        endcase
        queue_read(sel, idx);
        made++;
      end else if (roll < 90) begin
        queue_text(8'($urandom_range(0, 255)));
        made++;
      end else if (roll < 95) begin
        queue_item(tbh_pkg::CMD_END, 8'($urandom), 2'($urandom), 11'($urandom));
        made++;
      end else begin
        queue_item(CMD_UNUSED, 8'($urandom), 2'($urandom), 11'($urandom));
        made++;
      end
    end
  endtask

  // Waits until every item is through and every read has come back, then lets the
  // pipeline empty before anything else happens. Sampling is on the falling edge
  // so that it never races the clocked driver and monitor.
  task automatic drain();
    int guard;
    @(negedge clk);
    while (pend_q.size() != 0 || in_ch.valid) @(negedge clk);
    guard = 0;
    while (read_q.size() != 0 && guard < DRAIN_MAX) begin
      @(negedge clk);
      guard++;
    end
    if (read_q.size() != 0) begin
      errors++;
      $display("%0t: reads never returned, expected %0d more results, got none",
               $time, read_q.size());
      read_q.delete();
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = tbh_pkg::CFG_INCLUDE_SYMBOLS;
    cfg_wdata           = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = tbh_pkg::CMD_TEXT;
    in_ch.char_byte     = 8'h00;
    in_ch.table_select  = tbh_pkg::SEL_BIGRAM;
    in_ch.read_index    = '0;
    out_ch.ready        = 1'b0;
    errors              = 0;
    in_count            = 0;
    reads_checked       = 0;
    settings_used       = 0;
    snd_idle_pct        = 0;
    rcv_idle_pct        = 0;
    gen_prev            = 0;
    gen_cur             = 0;
    sym_on              = 1'b0;
    link_words          = 1'b0;
    last_key            = -1;
    chain_cut           = 1'b0;
    word_len            = 0;
    foreach (pair_cnt[i]) pair_cnt[i] = '0;
    foreach (freq_cnt[i]) freq_cnt[i] = '0;
    foreach (head_cnt[i]) head_cnt[i] = '0;
    foreach (len_cnt[i])  len_cnt[i]  = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The counter clearing pass after reset simply holds ready low, so the first
    // phase can be queued right away and waits behind it.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        snd_idle_pct = 17;
        rcv_idle_pct = 86;
      end else if (p < 4) begin
        snd_idle_pct = 86;
        rcv_idle_pct = 17;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      set_mode(sym_plan[p], link_plan[p]);
      @(negedge clk);
      if (p == 0) load_directed();
      fill_random(PER_PHASE);
      drain();
    end

    $display("Run covered %0d input transfers with %0d read results checked,",
             in_count, reads_checked);
    $display("across %0d register settings and three sender/receiver stall mixes.",
             settings_used);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(CLK_PERIOD * 300000);
    $display("%0t: timeout, the run did not reach its end", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tbh_pkg.sv
hw/rtl/tbh_in_if.sv
hw/rtl/tbh_out_if.sv
hw/rtl/tbh_ram.sv
hw/rtl/tbh_front.sv
hw/rtl/tbh_queue.sv
hw/rtl/tbh_back.sv
hw/rtl/text_bigram_histogram_unit.sv
dv/text_bigram_histogram_unit_test.sv
